// ----- hw/rtl/tvc_pkg.sv -----
// Package of the timed valve controller: mode codes, register indexes and shared types.
package tvc_pkg;

	localparam int unsigned CfgIndexWidth = 4;
	localparam int unsigned CfgDataWidth = 24;

	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_AUTO = 2'd1;
	localparam logic [1:0] MODE_ON = 2'd2;

	localparam logic [CfgIndexWidth-1:0] CFG_SETPOINT = 4'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_HALF_HYST = 4'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_OPEN_DURATION = 4'd2;
	localparam logic [CfgIndexWidth-1:0] CFG_COOLDOWN = 4'd3;

	localparam logic signed [13:0] SETPOINT_RST = 14'sd1800;
	localparam logic [9:0] HALF_HYST_RST = 10'd10;
	localparam logic [23:0] OPEN_DURATION_RST = 24'd10000;
	localparam logic [23:0] COOLDOWN_RST = 24'd120000;

	typedef struct packed {
		logic signed [13:0] setpoint;
		logic [9:0] half_hysteresis;
		logic [23:0] open_duration;
		logic [23:0] cooldown;
	} cfg_t;

	typedef struct packed {
		logic switch_a;
		logic switch_b;
		logic temp_valid;
		logic signed [14:0] temperature;
	} tick_t;

	typedef struct packed {
		logic valve_open;
		logic [1:0] mode;
		logic mode_changed;
		logic pulse_active;
	} result_t;

endpackage

// ----- hw/rtl/tvc_if.sv -----
// Channel interfaces of the timed valve controller: tick input, result output, register writes.
interface tvc_tick_if;
	logic valid;
	logic ready;
	logic switch_a;
	logic switch_b;
	logic temp_valid;
	logic signed [14:0] temperature;

	modport source (output valid, switch_a, switch_b, temp_valid, temperature, input ready);
	modport sink (input valid, switch_a, switch_b, temp_valid, temperature, output ready);
endinterface

interface tvc_result_if;
	logic valid;
	logic ready;
	logic valve_open;
	logic [1:0] mode;
	logic mode_changed;
	logic pulse_active;

	modport source (output valid, valve_open, mode, mode_changed, pulse_active, input ready);
	modport sink (input valid, valve_open, mode, mode_changed, pulse_active, output ready);
endinterface

interface tvc_cfg_if;
	logic valid;
	logic ready;
	logic [3:0] index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/tvc_cfg_regs.sv -----
// Configuration register file of the timed valve controller.
module tvc_cfg_regs
	import tvc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [CfgIndexWidth-1:0] wr_index,
	input  logic [CfgDataWidth-1:0] wr_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint <= SETPOINT_RST;
			cfg_q.half_hysteresis <= HALF_HYST_RST;
			cfg_q.open_duration <= OPEN_DURATION_RST;
			cfg_q.cooldown <= COOLDOWN_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SETPOINT: cfg_q.setpoint <= signed'(wr_data[13:0]);
				CFG_HALF_HYST: cfg_q.half_hysteresis <= wr_data[9:0];
				CFG_OPEN_DURATION: cfg_q.open_duration <= wr_data;
				CFG_COOLDOWN: cfg_q.cooldown <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/tvc_core.sv -----
// Mode decoder, valve state and elapsed-time counters with the result register.
module tvc_core
	import tvc_pkg::*;
#(
	parameter int unsigned COUNTER_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  tick_t tick,
	input  cfg_t cfg,
	output result_t result
);

	localparam int unsigned CmpWidth = (COUNTER_WIDTH > 24) ? COUNTER_WIDTH : 24;

	logic [1:0] last_mode_q;
	logic auto_open_q;
	logic valve_q;
	logic [COUNTER_WIDTH-1:0] time_in_state_q;
	logic [COUNTER_WIDTH-1:0] since_open_q;
	logic [COUNTER_WIDTH-1:0] uptime_q;
	result_t result_q;

	logic [1:0] mode;
	logic changed;
	logic hot;
	logic signed [15:0] threshold;
	logic cooled;
	logic pulse_done;
	logic [CmpWidth-1:0] uptime_ext;
	logic [CmpWidth-1:0] cooldown_ext;
	logic auto_open_d;
	logic valve_d;
	logic [COUNTER_WIDTH-1:0] tis_d;
	logic [COUNTER_WIDTH-1:0] so_d;
	logic [COUNTER_WIDTH-1:0] so_entry;

	function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] x);
		return (&x) ? x : x + 1'b1;
	endfunction

	always_comb begin
		if (!tick.switch_a && tick.switch_b) begin
			mode = MODE_OFF;
		end else if (tick.switch_a && !tick.switch_b) begin
			mode = MODE_ON;
		end else if (tick.switch_a && tick.switch_b) begin
			mode = MODE_AUTO;
		end else begin
			mode = last_mode_q;
		end
	end

	assign changed = (mode != last_mode_q);
	assign threshold = 16'(cfg.setpoint) + signed'({6'd0, cfg.half_hysteresis});
	assign hot = tick.temp_valid && (16'(tick.temperature) > threshold);

	assign uptime_ext = CmpWidth'(uptime_q);
	assign cooldown_ext = CmpWidth'(cfg.cooldown);
	assign so_entry = (uptime_ext >= cooldown_ext) ? COUNTER_WIDTH'(cfg.cooldown) : uptime_q;
	assign cooled = (CmpWidth'(since_open_q) >= cooldown_ext);
	assign pulse_done = (CmpWidth'(time_in_state_q) >= CmpWidth'(cfg.open_duration));

	always_comb begin
		auto_open_d = auto_open_q;
		valve_d = valve_q;
		tis_d = time_in_state_q;
		so_d = since_open_q;
		case (mode)
			MODE_OFF: begin
				auto_open_d = 1'b0;
				valve_d = 1'b0;
				tis_d = '0;
			end
			MODE_ON: begin
				auto_open_d = 1'b0;
				valve_d = 1'b1;
				tis_d = '0;
			end
			default: begin
				if (changed) begin
					so_d = so_entry;
					auto_open_d = 1'b0;
					valve_d = 1'b0;
					tis_d = '0;
					if (hot && (CmpWidth'(so_entry) >= cooldown_ext)) begin
						auto_open_d = 1'b1;
						valve_d = 1'b1;
						so_d = '0;
					end
				end else if (!auto_open_q) begin
					if (cooled && hot) begin
						auto_open_d = 1'b1;
						valve_d = 1'b1;
						tis_d = '0;
						so_d = '0;
					end
				end else if (pulse_done || !tick.temp_valid) begin
					auto_open_d = 1'b0;
					valve_d = 1'b0;
					tis_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mode_q <= MODE_AUTO;
			auto_open_q <= 1'b0;
			valve_q <= 1'b0;
			time_in_state_q <= '0;
			since_open_q <= '0;
			uptime_q <= '0;
		end else if (step) begin
			last_mode_q <= mode;
			auto_open_q <= auto_open_d;
			valve_q <= valve_d;
			time_in_state_q <= sat_inc(tis_d);
			since_open_q <= sat_inc(so_d);
			uptime_q <= sat_inc(uptime_q);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q.valve_open <= valve_d;
			result_q.mode <= mode;
			result_q.mode_changed <= changed;
			result_q.pulse_active <= auto_open_d;
		end
	end

	assign result = result_q;

endmodule

// ----- hw/rtl/timed_valve_controller.sv -----
// Top level of the timed valve controller: input register, core and output handshake.
// A transferred tick is held in the input register, and its result is then stored in the core's result register.
// Throughput: one tick per cycle while result.ready does not stall the output register.
// A stalled result holds while one further tick waits in the input register.
// Reset (arst_n low, asynchronous) restores the register defaults, AUTO as last mode,
// a closed valve and zeroed counters, and empties both stages.
module timed_valve_controller
	import tvc_pkg::*;
#(
	parameter int unsigned COUNTER_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	tvc_tick_if.sink tick,
	tvc_result_if.source result,
	tvc_cfg_if.sink cfg
);

	logic valid_s1;
	tick_t tick_s1;
	logic out_valid_q;
	logic out_free;
	logic step;
	cfg_t cfg_regs;
	result_t result_s2;

	assign out_free = !out_valid_q || result.ready;
	assign step = valid_s1 && out_free;
	assign tick.ready = !valid_s1 || out_free;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.switch_a <= tick.switch_a;
			tick_s1.switch_b <= tick.switch_b;
			tick_s1.temp_valid <= tick.temp_valid;
			tick_s1.temperature <= tick.temperature;
		end
	end

	tvc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid && cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	tvc_core #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.tick   (tick_s1),
		.cfg    (cfg_regs),
		.result (result_s2)
	);

	assign result.valid = out_valid_q;
	assign result.valve_open = result_s2.valve_open;
	assign result.mode = result_s2.mode;
	assign result.mode_changed = result_s2.mode_changed;
	assign result.pulse_active = result_s2.pulse_active;

	a_off_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.mode == MODE_OFF) |-> !result.valve_open)
		else $error("Valve reported open in OFF mode.");

	a_on_open: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.mode == MODE_ON) |-> (result.valve_open && !result.pulse_active))
		else $error("ON mode without an open valve or with a pulse active.");

	a_pulse_auto: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.pulse_active) |-> (result.mode == MODE_AUTO && result.valve_open))
		else $error("Pulse active outside AUTO or with a closed valve.");

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("Result lost after a state update.");

endmodule
